>>> src/sto_pkg.sv
// ---------------------------------------------------------------------------
// sto_pkg
// types, constants and the divide step shared by the offset generator
// ---------------------------------------------------------------------------
`default_nettype none

package sto_pkg;

    localparam int MAX_RANK   = 4;
    localparam int IDX_W      = 63;
    localparam int CRD_W      = 16;
    localparam int STRIDE_W   = 32;
    localparam int BASE_W     = 48;
    localparam int OFS_W      = 51;
    localparam int PROD_W     = CRD_W + STRIDE_W;
    localparam int RANK_W     = 3;
    localparam int DIV_BITS   = 7;
    localparam int DIV_STG    = IDX_W / DIV_BITS;
    localparam int NUM_DIV    = MAX_RANK * DIV_STG;
    localparam int NUM_STG    = NUM_DIV + 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    typedef enum logic [2:0] {
        REG_RANK         = 3'd0,
        REG_BASE_OFFSET  = 3'd1,
        REG_DIM_SIZES    = 3'd2,
        REG_STRIDES_LOW  = 3'd3,
        REG_STRIDES_HIGH = 3'd4,
        REG_ELEM_COUNT   = 3'd5
    } reg_idx_t;

    typedef enum logic {
        OP_LINEAR = 1'b0,
        OP_COORD  = 1'b1
    } op_t;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] flat_index;
        logic [CRD_W-1:0] coord_0;
        logic [CRD_W-1:0] coord_1;
        logic [CRD_W-1:0] coord_2;
        logic [CRD_W-1:0] coord_3;
    } req_t;

    typedef struct packed {
        logic [OFS_W-1:0] storage_offset;
        logic             status;
    } rsp_t;

    typedef struct packed {
        logic                           op;
        logic                           bad;
        logic [IDX_W-1:0]               n;
        logic [CRD_W-1:0]               p;
        logic [MAX_RANK-1:0][CRD_W-1:0] coord;
    } pipe_t;

    typedef struct packed {
        logic [IDX_W-1:0] n;
        logic [CRD_W-1:0] p;
    } div_t;

    function automatic div_t div_step(input logic [IDX_W-1:0] n,
                                      input logic [CRD_W-1:0] p,
                                      input logic [CRD_W-1:0] sz);
        div_t       r;
        logic [CRD_W:0] t;
        r.n = n;
        r.p = p;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {r.p, r.n[IDX_W-1]};
            if (t >= {1'b0, sz})
            begin
                r.p = CRD_W'(t - {1'b0, sz});
                r.n = {r.n[IDX_W-2:0], 1'b1};
            end
            else
            begin
                r.p = t[CRD_W-1:0];
                r.n = {r.n[IDX_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/strided_tensor_offset_generator.sv
// ---------------------------------------------------------------------------
// strided_tensor_offset_generator
// maps a linear index or a coordinate tuple to a strided storage offset
// ---------------------------------------------------------------------------
// channel   dir   handshake              payload
// req       in    req_valid / req_stall  sto_pkg::req_t
// rsp       out   rsp_valid / rsp_stall  sto_pkg::rsp_t
// cfg       in    apb write / read       64-bit registers at 8*i
//
// one transfer per cycle while rsp_stall is low, through the pipeline
// 36 of its stages are the digit-serial dividers, 7 quotient bits each
// empty stages are filled while the output is stalled
// reset clears the valid bits and the registers to their reset values
// ---------------------------------------------------------------------------
`default_nettype none

module strided_tensor_offset_generator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sto_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [sto_pkg::DATA_W-1:0]   pwdata,
    output logic      [sto_pkg::DATA_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire sto_pkg::req_t                req_data,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output sto_pkg::rsp_t                     rsp_data
);

    localparam int ND  = sto_pkg::NUM_DIV;
    localparam int NS  = sto_pkg::NUM_STG;
    localparam int MUL = ND + 1;
    localparam int AD1 = ND + 2;
    localparam int AD2 = ND + 3;

    // configuration
    logic [sto_pkg::RANK_W-1:0]     rank_reg;
    logic [sto_pkg::BASE_W-1:0]     base_reg;
    logic [63:0]                    sizes_reg;
    logic [63:0]                    str_lo_reg;
    logic [63:0]                    str_hi_reg;
    logic [sto_pkg::IDX_W-1:0]      count_reg;
    logic                           wr_en;
    sto_pkg::reg_idx_t              wr_idx;
    logic [sto_pkg::RANK_W-1:0]     used_rank;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = sto_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg   <= '0;
            base_reg   <= '0;
            sizes_reg  <= '0;
            str_lo_reg <= '0;
            str_hi_reg <= '0;
            count_reg  <= sto_pkg::IDX_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                sto_pkg::REG_RANK:         rank_reg   <= pwdata[sto_pkg::RANK_W-1:0];
                sto_pkg::REG_BASE_OFFSET:  base_reg   <= pwdata[sto_pkg::BASE_W-1:0];
                sto_pkg::REG_DIM_SIZES:    sizes_reg  <= pwdata;
                sto_pkg::REG_STRIDES_LOW:  str_lo_reg <= pwdata;
                sto_pkg::REG_STRIDES_HIGH: str_hi_reg <= pwdata;
                sto_pkg::REG_ELEM_COUNT:   count_reg  <= pwdata[sto_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sto_pkg::reg_idx_t'(paddr[5:3]))
            sto_pkg::REG_RANK:         prdata = 64'(rank_reg);
            sto_pkg::REG_BASE_OFFSET:  prdata = 64'(base_reg);
            sto_pkg::REG_DIM_SIZES:    prdata = sizes_reg;
            sto_pkg::REG_STRIDES_LOW:  prdata = str_lo_reg;
            sto_pkg::REG_STRIDES_HIGH: prdata = str_hi_reg;
            sto_pkg::REG_ELEM_COUNT:   prdata = 64'(count_reg);
            default:                   prdata = '0;
        endcase
    end

    assign used_rank = (rank_reg > sto_pkg::RANK_W'(sto_pkg::MAX_RANK))
                     ? sto_pkg::RANK_W'(sto_pkg::MAX_RANK) : rank_reg;

    logic [sto_pkg::CRD_W-1:0]    size_of   [sto_pkg::MAX_RANK];
    logic [sto_pkg::STRIDE_W-1:0] stride_of [sto_pkg::MAX_RANK];

    assign size_of[0]   = sizes_reg[15:0];
    assign size_of[1]   = sizes_reg[31:16];
    assign size_of[2]   = sizes_reg[47:32];
    assign size_of[3]   = sizes_reg[63:48];
    assign stride_of[0] = str_lo_reg[31:0];
    assign stride_of[1] = str_lo_reg[63:32];
    assign stride_of[2] = str_hi_reg[31:0];
    assign stride_of[3] = str_hi_reg[63:32];

    // pipeline control: a stage loads when empty or when it drains
    logic [NS-1:0] valid_reg;
    logic [NS:0]   en;

    assign en[NS] = !rsp_stall;
    for (genvar i = 0; i < NS; i++)
    begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end

    assign req_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // entry stage: range checks
    sto_pkg::pipe_t pipe_reg [ND+1];
    sto_pkg::pipe_t pipe_next[ND+1];

    always_comb
    begin
        pipe_next[0].op    = req_data.operation;
        pipe_next[0].n     = req_data.flat_index;
        pipe_next[0].p     = '0;
        pipe_next[0].coord = {req_data.coord_3, req_data.coord_2,
                              req_data.coord_1, req_data.coord_0};
        if (sto_pkg::op_t'(req_data.operation) == sto_pkg::OP_LINEAR)
        begin
            pipe_next[0].bad = req_data.flat_index >= count_reg;
        end
        else
        begin
            pipe_next[0].bad = 1'b0;
            for (int k = 0; k < sto_pkg::MAX_RANK; k++)
            begin
                if ((sto_pkg::RANK_W'(k) < used_rank)
                    && (pipe_next[0].coord[k] >= size_of[k]))
                begin
                    pipe_next[0].bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pipe_reg[0] <= pipe_next[0];
        end
    end

    // divider stages, innermost dimension first
    for (genvar s = 1; s <= ND; s++)
    begin : g_div
        localparam int K   = sto_pkg::MAX_RANK - 1 - (s - 1) / sto_pkg::DIV_STG;
        localparam int SUB = (s - 1) % sto_pkg::DIV_STG;

        logic        act;
        sto_pkg::div_t dv;

        always_comb
        begin
            pipe_next[s] = pipe_reg[s-1];
            act = (sto_pkg::op_t'(pipe_reg[s-1].op) == sto_pkg::OP_LINEAR)
                  && !pipe_reg[s-1].bad
                  && (sto_pkg::RANK_W'(K) < used_rank);
            if (SUB == 0)
            begin
                pipe_next[s].p = '0;
                if (act && (size_of[K] == '0))
                begin
                    pipe_next[s].bad = 1'b1;
                    act = 1'b0;
                end
            end
            dv = sto_pkg::div_step(pipe_next[s].n, pipe_next[s].p, size_of[K]);
            if (act)
            begin
                pipe_next[s].n = dv.n;
                pipe_next[s].p = dv.p;
                if (SUB == sto_pkg::DIV_STG - 1)
                begin
                    pipe_next[s].coord[K] = dv.p;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    // products
    logic [sto_pkg::PROD_W-1:0] prod_reg [sto_pkg::MAX_RANK];
    logic                       mbad_reg;

    always_ff @(posedge clk)
    begin
        if (en[MUL])
        begin
            mbad_reg <= pipe_reg[ND].bad;
            for (int k = 0; k < sto_pkg::MAX_RANK; k++)
            begin
                if (sto_pkg::RANK_W'(k) < used_rank)
                begin
                    prod_reg[k] <= pipe_reg[ND].coord[k] * stride_of[k];
                end
                else
                begin
                    prod_reg[k] <= '0;
                end
            end
        end
    end

    // pair sums
    logic [sto_pkg::PROD_W:0] suma_reg;
    logic [sto_pkg::PROD_W:0] sumb_reg;
    logic                     abad_reg;

    always_ff @(posedge clk)
    begin
        if (en[AD1])
        begin
            abad_reg <= mbad_reg;
            suma_reg <= {1'b0, prod_reg[0]} + {1'b0, prod_reg[1]};
            sumb_reg <= {1'b0, prod_reg[2]} + {1'b0, prod_reg[3]};
        end
    end

    // final sum into the output register
    logic [sto_pkg::OFS_W-1:0] total;

    assign total = sto_pkg::OFS_W'(base_reg) + sto_pkg::OFS_W'(suma_reg)
                 + sto_pkg::OFS_W'(sumb_reg);

    always_ff @(posedge clk)
    begin
        if (en[AD2])
        begin
            rsp_data.status         <= abad_reg;
            rsp_data.storage_offset <= abad_reg ? '0 : total;
        end
    end

    assign rsp_valid = valid_reg[AD2];

endmodule

`default_nettype wire

>>> src/sto_checker.sv
// ---------------------------------------------------------------------------
// sto_checker
// port-level checks for the offset generator
// ---------------------------------------------------------------------------
`default_nettype none

module sto_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          pready,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire sto_pkg::rsp_t rsp_data
);

    // held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // an error result carries no offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status |-> rsp_data.storage_offset == '0)
        else $error("error response with nonzero offset");

    // an empty output never pushes back on the request side
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with empty output");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // a stalled output with a full pipe blocks new transfers
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> !(rsp_valid && rsp_stall && $past(rsp_valid && rsp_stall)
            && $past(req_stall)))
        else $error("transfer taken while fully stalled");

endmodule

bind strided_tensor_offset_generator sto_checker u_sto_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

`default_nettype wire

>>> dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks the strided offset generator against a behavioral predictor: a
// table of directed lookups per layout, then random layouts and lookups with
// random gaps on the request side and random stalls on the response side
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int N_RANDOM  = 2000;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 60;

    typedef struct packed {
        logic                      chk;
        logic [sto_pkg::OFS_W-1:0] ofs;
        logic                      st;
    } known_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [sto_pkg::ADDR_W-1:0]  paddr = '0;
    logic [sto_pkg::DATA_W-1:0]  pwdata = '0;
    logic [sto_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        req_valid = 1'b0;
    logic                        req_stall;
    sto_pkg::req_t               req_data = '0;
    logic                        rsp_valid;
    logic                        rsp_stall = 1'b0;
    sto_pkg::rsp_t               rsp_data;

    logic [sto_pkg::RANK_W-1:0]  lay_rank;
    logic [sto_pkg::BASE_W-1:0]  lay_base;
    logic [63:0]                 lay_sizes;
    logic [63:0]                 lay_str_lo;
    logic [63:0]                 lay_str_hi;
    logic [sto_pkg::IDX_W-1:0]   lay_count;

    sto_pkg::rsp_t      offsets_due[$];
    known_t             known_due[$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    int                 n_lookups = 0;
    int                 n_bad = 0;
    bit                 stall_on = 1'b1;

    strided_tensor_offset_generator u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
    );

    always #6 clk = ~clk;

    function automatic logic [15:0] size_k(int k);
        return lay_sizes[16*k +: 16];
    endfunction

    function automatic logic [31:0] stride_k(int k);
        logic [63:0] w;
        w = (k >= 2) ? lay_str_hi : lay_str_lo;
        return (k % 2 == 1) ? w[63:32] : w[31:0];
    endfunction

    function automatic sto_pkg::rsp_t predict_offset(sto_pkg::req_t r);
        sto_pkg::rsp_t o;
        int          nr;
        logic [63:0] rem;
        logic [15:0] crd [4];
        logic [63:0] sum;
        bit          bad;
        nr = (lay_rank > sto_pkg::MAX_RANK) ? sto_pkg::MAX_RANK : int'(lay_rank);
        bad = 1'b0;
        crd[0] = r.coord_0; crd[1] = r.coord_1; crd[2] = r.coord_2; crd[3] = r.coord_3;
        if (sto_pkg::op_t'(r.operation) == sto_pkg::OP_LINEAR)
        begin
            rem = {1'b0, r.flat_index};
            if (rem >= {1'b0, lay_count})
                bad = 1'b1;
            for (int k = nr - 1; k >= 0 && !bad; k--)
            begin
                if (size_k(k) == 0)
                    bad = 1'b1;
                else
                begin
                    crd[k] = 16'(rem % size_k(k));
                    rem = rem / size_k(k);
                end
            end
        end
        else
        begin
            for (int k = 0; k < nr; k++)
                if (crd[k] >= size_k(k))
                    bad = 1'b1;
        end
        sum = {16'b0, lay_base};
        if (!bad)
            for (int k = 0; k < nr; k++)
                sum += {48'b0, crd[k]} * {32'b0, stride_k(k)};
        o.storage_offset = bad ? '0 : sum[sto_pkg::OFS_W-1:0];
        o.status = bad;
        return o;
    endfunction

    task automatic write_reg(sto_pkg::reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= sto_pkg::ADDR_W'(8 * int'(idx)); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            sto_pkg::REG_RANK:         lay_rank = val[sto_pkg::RANK_W-1:0];
            sto_pkg::REG_BASE_OFFSET:  lay_base = val[sto_pkg::BASE_W-1:0];
            sto_pkg::REG_DIM_SIZES:    lay_sizes = val;
            sto_pkg::REG_STRIDES_LOW:  lay_str_lo = val;
            sto_pkg::REG_STRIDES_HIGH: lay_str_hi = val;
            sto_pkg::REG_ELEM_COUNT:   lay_count = val[sto_pkg::IDX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_layout(logic [2:0] rk, logic [47:0] b, logic [63:0] sz,
                              logic [63:0] slo, logic [63:0] shi, logic [62:0] cnt);
        write_reg(sto_pkg::REG_RANK, {61'b0, rk});
        write_reg(sto_pkg::REG_BASE_OFFSET, {16'b0, b});
        write_reg(sto_pkg::REG_DIM_SIZES, sz);
        write_reg(sto_pkg::REG_STRIDES_LOW, slo);
        write_reg(sto_pkg::REG_STRIDES_HIGH, shi);
        write_reg(sto_pkg::REG_ELEM_COUNT, {1'b0, cnt});
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (offsets_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic send_lookup(sto_pkg::req_t r, known_t kn);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                          : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall);
        offsets_due.push_back(predict_offset(r));
        known_due.push_back(kn);
        n_lookups++;
    endtask

    function automatic sto_pkg::req_t rand_lookup();
        sto_pkg::req_t r;
        int   nr;
        logic [15:0] c [4];
        r.operation = 1'($urandom_range(0, 1));
        nr = (lay_rank > sto_pkg::MAX_RANK) ? sto_pkg::MAX_RANK : int'(lay_rank);
        for (int k = 0; k < 4; k++)
        begin
            if (k < nr && size_k(k) != 0 && $urandom_range(0, 9) != 0)
                c[k] = 16'($urandom_range(0, int'(size_k(k)) - 1));
            else
                c[k] = 16'($urandom);
        end
        r.coord_0 = c[0]; r.coord_1 = c[1]; r.coord_2 = c[2]; r.coord_3 = c[3];
        if ($urandom_range(0, 9) == 0)
            r.flat_index = sto_pkg::IDX_W'({$urandom, $urandom});
        else if (lay_count != 0)
            r.flat_index = sto_pkg::IDX_W'({$urandom, $urandom} % {1'b0, lay_count});
        else
            r.flat_index = sto_pkg::IDX_W'($urandom);
        return r;
    endfunction

    task automatic random_layout(bit wide);
        logic [63:0] sz;
        logic [63:0] cnt;
        for (int k = 0; k < 4; k++)
            sz[16*k +: 16] = wide ? 16'($urandom) : 16'($urandom_range(0, 12));
        cnt = 64'd1;
        for (int k = 0; k < 4; k++)
            cnt = cnt * sz[16*k +: 16];
        if ($urandom_range(0, 3) == 0)
            cnt = cnt + 64'($urandom_range(0, 50));
        set_layout(3'($urandom_range(0, 7)), 48'({$urandom, $urandom}),
                   sz, {$urandom, $urandom}, {$urandom, $urandom}, cnt[62:0]);
    endtask

    always @(posedge clk)
    begin
        sto_pkg::rsp_t exp;
        known_t        kn;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (stall_on && ($urandom_range(0, 3) == 0))
            begin
                rsp_stall <= 1'b1;
                stall_left <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(5, 30))
                                                           : int'($urandom_range(0, 2));
            end
            else
                rsp_stall <= 1'b0;
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_valid && !rsp_stall)
            begin
                if (offsets_due.size() == 0)
                begin
                    $error("unexpected transfer: storage_offset %0h", rsp_data.storage_offset);
                    errors++;
                end
                else
                begin
                    exp = offsets_due.pop_front();
                    kn = known_due.pop_front();
                    if (kn.chk && (kn.ofs !== exp.storage_offset || kn.st !== exp.status))
                    begin
                        $error("table row disagrees with predictor: offset %0h status %0b",
                               kn.ofs, kn.st);
                        errors++;
                    end
                    if (rsp_data.storage_offset !== exp.storage_offset)
                    begin
                        $error("storage_offset expected %0h actual %0h",
                               exp.storage_offset, rsp_data.storage_offset);
                        errors++;
                    end
                    if (rsp_data.status !== exp.status)
                    begin
                        $error("status expected %0b actual %0b", exp.status, rsp_data.status);
                        errors++;
                    end
                    if (exp.status)
                        n_bad++;
                end
            end
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // directed lookups: operation, index, coordinates, check flag, offset, status
    typedef struct packed {
        logic                      op;
        logic [sto_pkg::IDX_W-1:0] idx;
        logic [63:0]               crd;
        known_t                    kn;
    } row_t;

    row_t tbl [$];

    task automatic run_table();
        sto_pkg::req_t r;
        foreach (tbl[i])
        begin
            r.operation = tbl[i].op;
            r.flat_index = tbl[i].idx;
            {r.coord_3, r.coord_2, r.coord_1, r.coord_0} = tbl[i].crd;
            send_lookup(r, tbl[i].kn);
        end
        tbl.delete();
    endtask

    initial
    begin
        lay_rank = 0; lay_base = 0; lay_sizes = 0;
        lay_str_lo = 0; lay_str_hi = 0; lay_count = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset layout: rank zero, count one
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd0, 64'd0, {1'b1, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd1, 64'd0, {1'b1, 51'd0, 1'b1}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'hFFFF_FFFF_FFFF_FFFF,
                       {1'b1, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, {63{1'b1}}, 64'd0, {1'b1, 51'd0, 1'b1}});
        run_table();
        wait_idle();

        // extremes: full sizes and strides, max base, rank clamped from 7
        set_layout(3'd7, {48{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {63{1'b1}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'hFFFE_FFFE_FFFE_FFFE,
                       {1'b0, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'hFFFF_0000_0000_0000,
                       {1'b1, 51'd0, 1'b1}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'd0,
                       {1'b1, 51'h0_FFFF_FFFF_FFFF, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, {63{1'b1}}, 64'd0, {1'b1, 51'd0, 1'b1}});
        tbl.push_back({sto_pkg::OP_LINEAR, {1'b0, {62{1'b1}}}, 64'd0,
                       {1'b0, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd0, 64'd0,
                       {1'b1, 51'h0_FFFF_FFFF_FFFF, 1'b0}});
        run_table();
        wait_idle();

        // zero-sized dimension, coordinates beyond rank, count above product
        set_layout(3'd2, 48'h10, 64'h0000_0000_0000_0003, 64'h0000_0002_0000_0007,
                   {64{1'b1}}, 63'd100);
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd1, 64'd0, {1'b1, 51'd0, 1'b1}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'hFFFF_FFFF_0000_0002,
                       {1'b1, 51'd0, 1'b1}});
        run_table();
        wait_idle();
        set_layout(3'd2, 48'h10, 64'h0000_0000_0005_0003, 64'h0000_0002_0000_0007,
                   {64{1'b1}}, 63'd100);
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'hFFFF_FFFF_0004_0002,
                       {1'b1, 51'h26, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd14, 64'd0, {1'b1, 51'h26, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd15, 64'd0, {1'b0, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd99, 64'd0, {1'b0, 51'd0, 1'b0}});
        tbl.push_back({sto_pkg::OP_LINEAR, 63'd100, 64'd0, {1'b1, 51'd0, 1'b1}});
        tbl.push_back({sto_pkg::OP_COORD, 63'd0, 64'h0000_0000_0005_0000,
                       {1'b1, 51'd0, 1'b1}});
        run_table();
        wait_idle();

        // random layouts, stall-free stretch on the first one
        for (int blk = 0; blk < 20; blk++)
        begin
            random_layout($urandom_range(0, 4) == 0);
            stall_on = (blk != 0);
            for (int i = 0; i < N_RANDOM / 20; i++)
                send_lookup(rand_lookup(), '0);
            wait_idle();
        end

        if (known_due.size() != 0 || offsets_due.size() != 0)
        begin
            $error("%0d expected transfers never arrived", offsets_due.size());
            errors++;
        end
        $display("covered %0d lookups over 24 layouts, %0d of them out of range",
                 n_lookups, n_bad);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> strided_tensor_offset_generator.f
src/sto_pkg.sv
src/strided_tensor_offset_generator.sv
src/sto_checker.sv
dv/tb.sv
